/* rtl/sps_pkg.sv */
`default_nettype none

package sps_pkg;

  // width of the number fields on the ports
  localparam int unsigned NUMBER_W  = 16;

  // number of prime store entries and width of the arithmetic
  localparam int unsigned CELLS     = 16;
  localparam int unsigned NUM_WIDTH = 16;

  // derived widths
  localparam int unsigned CNT_W = $clog2(CELLS + 1);
  localparam int unsigned IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned BIT_W = $clog2(NUM_WIDTH);

  // sequencer state codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NEXT = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

endpackage

`default_nettype wire

/* rtl/sps_if.sv */
`default_nettype none

// candidate channel
interface sps_cand_if
  import sps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] number;
  logic                restart;

  modport source (output valid, output number, output restart, input ready);
  modport sink   (input valid, input number, input restart, output ready);
endinterface

// prime result channel
interface sps_prime_if
  import sps_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [NUMBER_W-1:0] prime;
  logic                stored;

  modport source (output valid, output prime, output stored, input ready);
  modport sink   (input valid, input prime, input stored, output ready);
endinterface

`default_nettype wire

/* rtl/streaming_prime_sieve_core.sv */
`default_nettype none

// Streaming prime sieve.
// cand_i carries a candidate number and a restart bit. Restart empties the
// prime store before that number is handled. A number below two gives no
// result. Every other number is divided by each stored prime in turn; if
// none divides it, it leaves on prime_o with stored = 1 when it was appended
// to the store, or stored = 0 when the store already held CELLS primes.
// One transaction is worked at a time: cand_i.ready is high only while the
// sequencer is idle. A shared restoring divider produces one remainder bit
// per cycle; each stored prime passes a read step, a load step and NUM_WIDTH
// divide steps. A survivor goes through these for each stored prime and then
// the emit step, after which the sequencer is idle again and can take the
// next candidate; a number below two never leaves the idle state.
// A rejected number returns to idle on the divide step that finds a zero
// remainder. The result sits in an output register, so a new candidate may
// be accepted while it waits; if the receiver still stalls when the next
// result is ready, the sequencer holds in its emit step.
// Reset empties the store and clears the output valid; no clearing pass is
// needed since only entries below the fill count are ever used.

module streaming_prime_sieve_core
  import sps_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  sps_cand_if.sink          cand_i,
  sps_prime_if.source       prime_o
);

  logic [2:0]           state_q, state_d;
  logic [NUM_WIDTH-1:0] num_q, num_d;
  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [BIT_W-1:0]     bit_q, bit_d;
  logic [NUM_WIDTH-1:0] rem_q, rem_d;
  logic [NUM_WIDTH-1:0] div_q, div_d;

  logic [NUM_WIDTH-1:0] store_q [CELLS];
  logic [NUM_WIDTH-1:0] rd_q;

  logic                 out_valid_q, out_valid_d;
  logic [NUMBER_W-1:0]  out_prime_q, out_prime_d;
  logic                 out_stored_q, out_stored_d;

  logic                 cand_fire;
  logic                 out_free;
  logic                 store_we;
  logic                 has_room;
  logic [NUM_WIDTH:0]   rem_sh;
  logic [NUM_WIDTH:0]   rem_diff;
  logic [NUM_WIDTH-1:0] rem_nxt;
  logic                 divisible;

  assign cand_i.ready  = (state_q == ST_IDLE);
  assign cand_fire     = cand_i.valid && cand_i.ready;
  assign out_free      = !out_valid_q || prime_o.ready;
  assign has_room      = (count_q < CNT_W'(CELLS));

  assign prime_o.valid  = out_valid_q;
  assign prime_o.prime  = out_prime_q;
  assign prime_o.stored = out_stored_q;

  // shared restoring divider step: one remainder bit per cycle
  assign rem_sh    = {rem_q, num_q[bit_q]};
  assign rem_diff  = rem_sh - {1'b0, div_q};
  assign rem_nxt   = rem_diff[NUM_WIDTH] ? rem_sh[NUM_WIDTH-1:0] : rem_diff[NUM_WIDTH-1:0];
  assign divisible = (rem_nxt == '0) && (div_q >= NUM_WIDTH'(2));

  // sequencer
  always_comb begin
    state_d      = state_q;
    num_d        = num_q;
    count_d      = count_q;
    idx_d        = idx_q;
    bit_d        = bit_q;
    rem_d        = rem_q;
    div_d        = div_q;
    out_valid_d  = out_valid_q && !prime_o.ready;
    out_prime_d  = out_prime_q;
    out_stored_d = out_stored_q;
    store_we     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cand_fire) begin
          num_d = cand_i.number[NUM_WIDTH-1:0];
          idx_d = '0;
          if (cand_i.restart) begin
            count_d = '0;
          end
          if (cand_i.number[NUM_WIDTH-1:0] >= NUM_WIDTH'(2)) begin
            state_d = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        if (idx_q == count_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        div_d   = rd_q;
        rem_d   = '0;
        bit_d   = BIT_W'(NUM_WIDTH - 1);
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d = rem_nxt;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          if (divisible) begin
            state_d = ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = ST_NEXT;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_prime_d  = NUMBER_W'(num_q);
          out_stored_d = has_room;
          if (has_room) begin
            store_we = 1'b1;
            count_d  = count_q + 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    num_q        <= num_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    out_prime_q  <= out_prime_d;
    out_stored_q <= out_stored_d;
  end

  // prime store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[IDX_W-1:0]] <= num_q;
    end
    rd_q <= store_q[idx_q[IDX_W-1:0]];
  end

  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CELLS))
    else $error("prime count exceeds store depth");

  // scan index stays within the filled part of the store
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> (idx_q <= count_q))
    else $error("scan index beyond fill count");

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < div_q))
    else $error("divider remainder out of range");

  // a stored result grows the store by one entry
  a_count_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && has_room) |=> (count_q == $past(count_q) + 1'b1))
    else $error("store count did not advance on stored prime");

  // a result reaches the output only from the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q || prime_o.ready) && $past(state_q) != ST_EMIT |-> !out_valid_q
      || $past(out_valid_q))
    else $error("result appeared without emit step");

endmodule

`default_nettype wire
